FILE: design/sha256_digest_engine_top_macros.svh
// Assertion helpers used by the checker in sha256_chk.sv.
`ifndef SHA256_DIGEST_ENGINE_TOP_MACROS_SVH
`define SHA256_DIGEST_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, masked while in reset.
`define SHA256_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("sha256 check failed");

// Next-cycle implication, masked while in reset.
`define SHA256_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("sha256 check failed");

`endif

FILE: design/sha256_pkg.sv
package sha256_pkg;

  localparam int unsigned NUM_ROUNDS = 64;
  localparam int unsigned BLK_WORDS  = 16;
  localparam int unsigned HASH_WORDS = 8;
  localparam int unsigned BLK_BYTES  = 64;

  localparam logic [2:0] MAX_BYTES = 3'd4;
  localparam logic [2:0] LAST_IDX  = 3'd7;
  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_FILL  = 6'd56;

  localparam logic [31:0] IV [HASH_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef logic [BLK_WORDS-1:0][31:0] blk_t;

  typedef struct packed {
    logic start;
    logic init;
  } cmp_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DATA,
    ST_PAD80,
    ST_PADZ,
    ST_LEN,
    ST_CSTART,
    ST_CWAIT,
    ST_OUT
  } seq_state_t;

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
  endfunction

  function automatic logic [31:0] ch_f(input logic [31:0] e, input logic [31:0] f,
                                       input logic [31:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] maj_f(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

FILE: design/sha256_if.sv
interface sha256_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] word_data;
  logic [2:0]  byte_count;
  logic        is_last;

  modport source (output valid, output word_data, output byte_count, output is_last,
                  input ready);
  modport sink   (input valid, input word_data, input byte_count, input is_last,
                  output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

FILE: design/sha256_compress.sv
module sha256_compress (
  input  logic               clk,
  input  logic               rst_n,
  input  sha256_pkg::cmp_cmd_t cmd,
  input  sha256_pkg::blk_t   block,
  input  logic [2:0]         rd_idx,
  output logic [31:0]        rd_word,
  output logic               busy
);
  import sha256_pkg::*;

  logic [31:0] wv_r    [HASH_WORDS];
  logic [31:0] wv_nxt  [HASH_WORDS];
  logic [31:0] w_r     [BLK_WORDS];
  logic [31:0] w_nxt   [BLK_WORDS];
  logic [31:0] chain_r [HASH_WORDS];
  logic [6:0]  round_r;
  logic        busy_r;
  logic        add_step;
  logic [31:0] t1;
  logic [31:0] t2;

  // round counter reaching 64 marks the feed-forward add
  assign add_step = round_r[6];

  always_comb begin
    t1 = wv_r[7] + big_sigma1(wv_r[4]) + ch_f(wv_r[4], wv_r[5], wv_r[6])
       + round_k(round_r[5:0]) + w_r[0];
    t2 = big_sigma0(wv_r[0]) + maj_f(wv_r[0], wv_r[1], wv_r[2]);
    wv_nxt[0] = t1 + t2;
    wv_nxt[1] = wv_r[0];
    wv_nxt[2] = wv_r[1];
    wv_nxt[3] = wv_r[2];
    wv_nxt[4] = wv_r[3] + t1;
    wv_nxt[5] = wv_r[4];
    wv_nxt[6] = wv_r[5];
    wv_nxt[7] = wv_r[6];
    // schedule window slides by one word per round
    for (int i = 0; i < BLK_WORDS - 1; i++) begin
      w_nxt[i] = w_r[i+1];
    end
    w_nxt[BLK_WORDS-1] = small_sigma1(w_r[14]) + w_r[9] + small_sigma0(w_r[1]) + w_r[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      round_r <= '0;
      for (int i = 0; i < HASH_WORDS; i++) begin
        chain_r[i] <= IV[i];
      end
    end else begin
      if (cmd.init) begin
        for (int i = 0; i < HASH_WORDS; i++) begin
          chain_r[i] <= IV[i];
        end
      end
      if (!busy_r) begin
        if (cmd.start) begin
          busy_r  <= 1'b1;
          round_r <= '0;
        end
      end else if (add_step) begin
        busy_r  <= 1'b0;
        round_r <= '0;
        for (int i = 0; i < HASH_WORDS; i++) begin
          chain_r[i] <= chain_r[i] + wv_r[i];
        end
      end else begin
        round_r <= round_r + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && cmd.start) begin
      for (int i = 0; i < HASH_WORDS; i++) begin
        wv_r[i] <= chain_r[i];
      end
      for (int i = 0; i < BLK_WORDS; i++) begin
        w_r[i] <= block[i];
      end
    end else if (busy_r && !add_step) begin
      wv_r <= wv_nxt;
      w_r  <= w_nxt;
    end
  end

  assign rd_word = chain_r[rd_idx];
  assign busy    = busy_r;

endmodule

FILE: design/sha256_digest_engine_top.sv
// Channel | Dir | Payload                               | Transaction
// in_s    | in  | word_data[31:0] byte_count[2:0] is_last | valid && ready
// out_s   | out | digest_word[31:0] word_index[2:0] last_word | valid && ready
//
// An item is taken in ST_IDLE; its bytes are packed one by one in ST_DATA.
// A filled block detours via the round unit: start, 64 rounds, add, resume.
// A last item adds the 0x80 marker, zeros up to byte 56, eight length bytes,
// one or two compressions and eight output transactions; in_s.ready stays low.
// Synchronous active-low reset; the block buffer needs no clearing pass.
// A stalled out_s holds its word; nothing else moves until it is taken.
module sha256_digest_engine_top (
  input  logic clk,
  input  logic rst_n,
  sha256_in_if.sink    in_s,
  sha256_out_if.source out_s
);
  import sha256_pkg::*;

  seq_state_t  state_r, state_nxt;
  seq_state_t  ret_r, ret_nxt;
  seq_state_t  after_st;

  logic [31:0] blk_r [BLK_WORDS];
  blk_t        blk_words;
  logic [5:0]  fill_r;
  logic [63:0] bits_r;
  logic [31:0] data_r;
  logic [2:0]  cnt_r;
  logic [2:0]  cnt_in;
  logic        last_r;
  logic [2:0]  len_idx_r;

  logic        in_ready;
  logic        in_take;
  logic        put_en;
  logic [7:0]  put_val;
  logic        wrap;
  logic        seq_done;
  logic        out_load;
  logic        out_take;
  cmp_cmd_t    cmd;
  logic        cmp_busy;
  logic [31:0] rd_word;

  logic        out_valid_r;
  logic [31:0] out_word_r;
  logic [2:0]  out_idx_r;
  logic        out_last_r;
  logic [2:0]  ld_idx_r;

  assign in_take  = in_s.valid && in_ready;
  assign out_take = out_valid_r && out_s.ready;
  assign cnt_in   = (in_s.byte_count > MAX_BYTES) ? MAX_BYTES : in_s.byte_count;
  assign wrap     = put_en && (fill_r == 6'(BLK_BYTES - 1));

  always_comb begin
    for (int j = 0; j < BLK_WORDS; j++) begin
      blk_words[j] = blk_r[j];
    end
  end

  // next state
  always_comb begin
    after_st = state_r;
    case (state_r)
      ST_IDLE:   after_st = in_take ? ST_DATA : ST_IDLE;
      ST_DATA:   begin
        if (cnt_r <= 3'd1) begin
          after_st = last_r ? ST_PAD80 : ST_IDLE;
        end else begin
          after_st = ST_DATA;
        end
      end
      ST_PAD80:  after_st = ST_PADZ;
      ST_PADZ:   after_st = (fill_r == LEN_FILL) ? ST_LEN : ST_PADZ;
      ST_LEN:    after_st = (len_idx_r == LAST_IDX) ? ST_OUT : ST_LEN;
      ST_CSTART: after_st = ST_CWAIT;
      ST_CWAIT:  after_st = cmp_busy ? ST_CWAIT : ret_r;
      ST_OUT:    after_st = seq_done ? ST_IDLE : ST_OUT;
      default:   after_st = ST_IDLE;
    endcase
    // a completed block detours through the round unit, then resumes
    if (wrap) begin
      state_nxt = ST_CSTART;
      ret_nxt   = after_st;
    end else begin
      state_nxt = after_st;
      ret_nxt   = ret_r;
    end
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    put_en    = 1'b0;
    put_val   = '0;
    cmd       = '0;
    seq_done  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_DATA:   begin
        put_en  = (cnt_r != 3'd0);
        put_val = data_r[31:24];
      end
      ST_PAD80:  begin
        put_en  = 1'b1;
        put_val = PAD_BYTE;
      end
      ST_PADZ:   put_en = (fill_r != LEN_FILL);
      ST_LEN:    begin
        put_en  = 1'b1;
        put_val = bits_r[{LAST_IDX - len_idx_r, 3'b000} +: 8];
      end
      ST_CSTART: cmd.start = 1'b1;
      ST_CWAIT:  ;
      ST_OUT:    begin
        seq_done = out_take && out_last_r;
        out_load = !seq_done && (!out_valid_r || out_take);
        cmd.init = seq_done;
      end
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      fill_r      <= '0;
      bits_r      <= '0;
      cnt_r       <= '0;
      last_r      <= 1'b0;
      len_idx_r   <= '0;
      out_valid_r <= 1'b0;
      ld_idx_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      if (in_take) begin
        cnt_r  <= cnt_in;
        last_r <= in_s.is_last;
      end else if (put_en && state_r == ST_DATA) begin
        cnt_r  <= cnt_r - 3'd1;
        bits_r <= bits_r + 64'd8;
      end
      if (put_en) begin
        fill_r <= fill_r + 6'd1;
      end
      if (put_en && state_r == ST_LEN) begin
        len_idx_r <= len_idx_r + 3'd1;
      end
      if (seq_done) begin
        bits_r      <= '0;
        out_valid_r <= 1'b0;
        ld_idx_r    <= '0;
      end else if (out_load) begin
        out_valid_r <= 1'b1;
        ld_idx_r    <= ld_idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      data_r <= in_s.word_data;
    end else if (put_en && state_r == ST_DATA) begin
      data_r <= {data_r[23:0], 8'h00};
    end
    // place the byte in its big-endian lane of the current word
    if (put_en) begin
      blk_r[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= put_val;
    end
    if (out_load) begin
      out_word_r <= rd_word;
      out_idx_r  <= ld_idx_r;
      out_last_r <= (ld_idx_r == LAST_IDX);
    end
  end

  sha256_compress u_compress (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .block   (blk_words),
    .rd_idx  (ld_idx_r),
    .rd_word (rd_word),
    .busy    (cmp_busy)
  );

  assign in_s.ready        = in_ready;
  assign out_s.valid       = out_valid_r;
  assign out_s.digest_word = out_word_r;
  assign out_s.word_index  = out_idx_r;
  assign out_s.last_word   = out_last_r;

endmodule

FILE: design/sha256_chk.sv
`include "sha256_digest_engine_top_macros.svh"

module sha256_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word
);
  import sha256_pkg::*;

  // no new message is taken while digest words are pending
  `SHA256_ASSERT_IMP(a_no_in_during_out, clk, rst_n, out_valid, !in_ready)
  `SHA256_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(digest_word) && $stable(word_index))
  // digest words go out back to back in index order
  `SHA256_ASSERT_NXT(a_idx_step, clk, rst_n, out_valid && out_ready && !last_word, out_valid && (word_index == $past(word_index) + 3'd1))
  `SHA256_ASSERT_IMP(a_last_pos, clk, rst_n, out_valid, last_word == (word_index == LAST_IDX))
  // an accepted word holds in_ready low while it is packed, with no digest word offered
  `SHA256_ASSERT_NXT(a_in_busy, clk, rst_n, in_valid && in_ready, !in_ready && !out_valid)

endmodule

bind sha256_digest_engine_top sha256_chk u_sha256_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_s.valid),
  .in_ready    (in_s.ready),
  .out_valid   (out_s.valid),
  .out_ready   (out_s.ready),
  .digest_word (out_s.digest_word),
  .word_index  (out_s.word_index),
  .last_word   (out_s.last_word)
);

FILE: tb/sha256_tb_pkg.sv
package sha256_tb_pkg;

  localparam bit [31:0] START_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam bit [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam bit [7:0] PAD_MARK   = 8'h80;
  localparam int       LEN_OFFSET = 56;

  typedef struct {
    bit [31:0] word;
    bit [2:0]  idx;
    bit        last;
  } digest_entry_t;

  function automatic bit [31:0] rotr(input bit [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  class digest_scoreboard;
    bit [31:0]     chain [8];
    bit [7:0]      blk [64];
    int unsigned   fill;
    bit [63:0]     msg_bits;
    digest_entry_t expected_digest [$];
    int unsigned   errors;
    int unsigned   words_in;
    int unsigned   messages;
    int unsigned   words_checked;

    function new();
      chain = START_HASH;
      fill = 0;
      msg_bits = '0;
      errors = 0;
      words_in = 0;
      messages = 0;
      words_checked = 0;
    endfunction

    function void compress();
      bit [31:0] w [16];
      bit [31:0] v [8];
      bit [31:0] s0, s1, t1, t2;
      for (int i = 0; i < 16; i++)
        w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      v = chain;
      for (int r = 0; r < 64; r++) begin
        // extend the schedule in place over a 16-word window
        if (r >= 16) begin
          s0 = rotr(w[(r+1)%16], 7) ^ rotr(w[(r+1)%16], 18) ^ (w[(r+1)%16] >> 3);
          s1 = rotr(w[(r+14)%16], 17) ^ rotr(w[(r+14)%16], 19) ^ (w[(r+14)%16] >> 10);
          w[r%16] = w[r%16] + s0 + w[(r+9)%16] + s1;
        end
        t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[r%16];
        t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++)
        chain[i] = chain[i] + v[i];
    endfunction

    function void absorb_byte(input bit [7:0] b);
      blk[fill] = b;
      fill = (fill + 1) % 64;
      if (fill == 0)
        compress();
    endfunction

    function void note_input(input bit [31:0] data, input bit [2:0] cnt, input bit last);
      int unsigned n;
      digest_entry_t e;
      words_in++;
      n = (cnt > 4) ? 4 : cnt;
      for (int i = 0; i < n; i++)
        absorb_byte(data[31-8*i -: 8]);
      msg_bits = msg_bits + 64'(n * 8);
      if (!last)
        return;
      // pad: marker, zeros up to the length field, then the bit length
      absorb_byte(PAD_MARK);
      if (fill > LEN_OFFSET) begin
        while (fill != 0)
          absorb_byte(8'h00);
      end
      while (fill < LEN_OFFSET)
        absorb_byte(8'h00);
      for (int i = 0; i < 8; i++)
        absorb_byte(msg_bits[63-8*i -: 8]);
      for (int i = 0; i < 8; i++) begin
        e.word = chain[i];
        e.idx = 3'(i);
        e.last = (i == 7);
        expected_digest = {expected_digest, e};
      end
      messages++;
      chain = START_HASH;
      fill = 0;
      msg_bits = '0;
    endfunction

    function void check_result(input logic [31:0] word, input logic [2:0] idx,
                               input logic last, input longint unsigned stamp);
      digest_entry_t e;
      words_checked++;
      if (expected_digest.size() == 0) begin
        errors++;
        $display("%0d ns: unexpected digest word %h idx %0d last %0b",
                 stamp, word, idx, last);
        return;
      end
      e = expected_digest.pop_front();
      if (word !== e.word || idx !== e.idx || last !== e.last) begin
        errors++;
        $display("%0d ns: digest mismatch, expected %h idx %0d last %0b, got %h idx %0d last %0b",
                 stamp, e.word, e.idx, e.last, word, idx, last);
      end
    endfunction

    function int unsigned pending();
      return expected_digest.size();
    endfunction
  endclass

endpackage

FILE: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sha256_tb_pkg::*;

  localparam int NUM_DIRECTED = 12;
  localparam int RANDOM_ITEMS = 270;

  // empty message, "abc", oversize byte counts, short words mid-message;
  // low bits below the valid bytes of the short words carry junk
  localparam bit [31:0] DIR_DATA [NUM_DIRECTED] = '{
    32'hdeadbeef, 32'h616263ff,
    32'hffffffff, 32'h00000000, 32'ha5a5a5a5, 32'h5a5a5a5a,
    32'h01020304, 32'h05060708, 32'h090a0b0c, 32'hffffffff, 32'h11223344, 32'h55667788
  };
  localparam bit [2:0] DIR_COUNT [NUM_DIRECTED] = '{
    3'd0, 3'd3,
    3'd4, 3'd5, 3'd6, 3'd7,
    3'd1, 3'd2, 3'd3, 3'd0, 3'd4, 3'd2
  };
  localparam bit DIR_LAST [NUM_DIRECTED] = '{
    1'b1, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1
  };

  logic clk;
  logic rst_n;
  bit   in_calm;
  bit   out_calm;
  int unsigned random_sent;

  sha256_in_if  in_ch ();
  sha256_out_if out_ch ();

  digest_scoreboard sb;

  sha256_digest_engine_top uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_ch),
    .out_s (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("sha256_digest_engine_top test failed");
    $finish;
  end

  task automatic send_item(input bit [31:0] data, input bit [2:0] cnt, input bit last);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.word_data  <= data;
    in_ch.byte_count <= cnt;
    in_ch.is_last    <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_input(data, cnt, last);
  endtask

  // drop valid and hold off until every digest word has been taken
  task automatic hold_until_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic send_random_message();
    int unsigned nwords;
    bit [2:0] cnt;
    nwords = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 34) : $urandom_range(0, 16);
    for (int i = 0; i < nwords; i++) begin
      cnt = ($urandom_range(0, 99) < 85) ? 3'd4 : 3'($urandom_range(0, 7));
      send_item($urandom, cnt, 1'b0);
      random_sent++;
    end
    send_item($urandom, 3'($urandom_range(0, 7)), 1'b1);
    random_sent++;
  endtask

  // result side: random stalls per digest word, with calm stretches
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (sb.words_checked % 16 == 0)
        out_calm = ($urandom_range(0, 3) == 0);
      stall = out_calm ? 0 : $urandom_range(0, 9);
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      sb.check_result(out_ch.digest_word, out_ch.word_index, out_ch.last_word, $time);
    end
  end

  initial begin
    int unsigned msg_no;
    sb = new();
    in_ch.valid      = 1'b0;
    in_ch.word_data  = '0;
    in_ch.byte_count = '0;
    in_ch.is_last    = 1'b0;
    in_calm = 1'b0;
    out_calm = 1'b0;
    random_sent = 0;
    msg_no = 0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++)
      send_item(DIR_DATA[i], DIR_COUNT[i], DIR_LAST[i]);
    hold_until_drained();

    while (random_sent < RANDOM_ITEMS) begin
      in_calm = ($urandom_range(0, 4) == 0);
      send_random_message();
      msg_no++;
      if (msg_no % 5 == 0)
        hold_until_drained();
    end

    hold_until_drained();
    repeat (200) @(posedge clk);

    $display("Hashed %0d messages from %0d input words; %0d digest words checked.",
             sb.messages, sb.words_in, sb.words_checked);
    $display("Covered empty and short tails, oversize byte counts and one- and two-block padding.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("sha256_digest_engine_top test passed");
    end else begin
      $display("sha256_digest_engine_top test failed");
    end
    $finish;
  end

endmodule
